// ===== rtl/twrr_pkg.sv =====
// ----------------------------------------------------------------------------
// twrr_pkg: shared types and constants for the tick wake scheduler
// Task table geometry, status and cause codes, channel payloads and the
// control/status bundle between the sequencer and the table scan unit.
// ----------------------------------------------------------------------------
package twrr_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int TBL_W      = 2 + 64;

	localparam logic [1:0] ST_READY   = 2'd0;
	localparam logic [1:0] ST_BLOCKED = 2'd1;
	localparam logic [1:0] ST_IDLE    = 2'd2;

	localparam logic [7:0] CODE_TIMER = 8'd7;
	localparam logic [7:0] CODE_SOFT  = 8'd3;

	localparam logic CMD_TRAP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [31:0] TICK_INTERVAL_RST = 32'd100000;

	typedef logic [IDX_W-1:0] slot_t;

	typedef struct packed {
		logic        cmd;
		logic        irq;
		logic [7:0]  cause_code;
		logic [63:0] trap_sp;
		logic [63:0] mtime_now;
		logic [2:0]  load_index;
		logic [1:0]  load_status;
		logic [63:0] load_wake;
		logic [63:0] load_sp;
	} req_t;

	typedef struct packed {
		logic [63:0] resume_sp;
		logic [2:0]  running_index;
		logic [63:0] compare_value;
		logic        compare_write;
		logic        soft_pending;
		logic        soft_write;
	} rsp_t;

	typedef struct packed {
		logic        start;
		logic        timer_mode;
		slot_t       first;
		logic        load_we;
		slot_t       load_idx;
		logic [1:0]  load_status;
		logic [63:0] load_wake;
	} scan_ctrl_t;

	typedef struct packed {
		logic  done;
		logic  found;
		slot_t hit_idx;
	} scan_stat_t;

	// Round-robin successor of a slot, wrapping at the table end
	function automatic slot_t next_slot(slot_t s);
		return (s == slot_t'(TASK_SLOTS - 1)) ? '0 : s + slot_t'(1);
	endfunction

endpackage

// ===== rtl/twrr_if.sv =====
// ----------------------------------------------------------------------------
// twrr_req_if / twrr_rsp_if: valid/ready channels of the scheduler
// Request channel carries one trap or load command, response channel one
// result.
// ----------------------------------------------------------------------------
interface twrr_req_if;
	logic              valid;
	logic              ready;
	twrr_pkg::req_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface twrr_rsp_if;
	logic              valid;
	logic              ready;
	twrr_pkg::rsp_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/twrr_ram.sv =====
// ----------------------------------------------------------------------------
// twrr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module twrr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/twrr_scan.sv =====
// ----------------------------------------------------------------------------
// twrr_scan: task table and shared slot scan unit
// Holds status and wake tick per slot and walks the table one slot a cycle
// through one compare unit: wake blocked tasks, or find the next ready one.
// ----------------------------------------------------------------------------
module twrr_scan (
	input  logic                    clk,
	input  logic                    arst_n,
	input  twrr_pkg::scan_ctrl_t    ctrl,
	input  logic [63:0]             tick,
	output twrr_pkg::scan_stat_t    stat
);
	import twrr_pkg::*;

	logic [TASK_SLOTS-1:0] valid_q;
	logic                  active_q;
	logic                  mode_q;
	logic [CNT_W-1:0]      cnt_q;
	slot_t                 ptr_q;
	logic                  rd_vld_s1;
	slot_t                 rd_idx_s1;
	logic                  found_q;
	slot_t                 hit_q;
	logic                  done_q;

	logic                  tbl_we;
	slot_t                 tbl_waddr;
	logic [TBL_W-1:0]      tbl_wdata;
	logic [TBL_W-1:0]      tbl_rdata;

	logic [1:0]            eff_status;
	logic [63:0]           eff_wake;
	logic                  hit;
	logic                  issue;

	twrr_ram #(.WIDTH(TBL_W), .DEPTH(TASK_SLOTS)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (ptr_q),
		.rdata (tbl_rdata)
	);

	// never-loaded slots read as their reset value
	always_comb begin
		eff_status = valid_q[rd_idx_s1] ? tbl_rdata[TBL_W-1 -: 2] : ST_IDLE;
		eff_wake   = valid_q[rd_idx_s1] ? tbl_rdata[63:0] : 64'd0;
		if (mode_q) begin
			hit = (eff_status == ST_BLOCKED) && (tick >= eff_wake);
		end else begin
			hit = (eff_status == ST_READY);
		end
	end

	assign issue = active_q && (cnt_q < CNT_W'(TASK_SLOTS));

	always_comb begin
		if (ctrl.load_we) begin
			tbl_we    = 1'b1;
			tbl_waddr = ctrl.load_idx;
			tbl_wdata = {ctrl.load_status, ctrl.load_wake};
		end else begin
			tbl_we    = rd_vld_s1 && mode_q && hit;
			tbl_waddr = rd_idx_s1;
			tbl_wdata = {ST_READY, eff_wake};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			active_q  <= 1'b0;
			mode_q    <= 1'b0;
			cnt_q     <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			found_q   <= 1'b0;
			hit_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.load_we) begin
				valid_q[ctrl.load_idx] <= 1'b1;
			end
			if (ctrl.start) begin
				active_q <= 1'b1;
				mode_q   <= ctrl.timer_mode;
				cnt_q    <= '0;
				ptr_q    <= ctrl.first;
				found_q  <= 1'b0;
			end else if (issue) begin
				ptr_q <= next_slot(ptr_q);
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (active_q) begin
				// last read is being evaluated this cycle
				active_q <= 1'b0;
				done_q   <= 1'b1;
			end
			rd_vld_s1 <= issue;
			rd_idx_s1 <= ptr_q;
			// keep the first ready slot in scan order
			if (rd_vld_s1 && !mode_q && hit && !found_q) begin
				found_q <= 1'b1;
				hit_q   <= rd_idx_s1;
			end
		end
	end

	assign stat.done    = done_q;
	assign stat.found   = found_q;
	assign stat.hit_idx = hit_q;

endmodule

// ===== rtl/tick_wake_round_robin_scheduler.sv =====
// ----------------------------------------------------------------------------
// tick_wake_round_robin_scheduler: trap-driven round-robin task scheduler
// Load, exception and other interrupt requests: decode, then the output state.
// Timer interrupt: decode, the one-slot-a-cycle wake pass of the table scan, then output.
// Software interrupt: decode, table scan, stack pointer RAM read (SPRD, SPDAT), then output.
// One request in flight; a finished result waits in the output register.
// Reset clears control state and the per-slot valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module tick_wake_round_robin_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	twrr_req_if.sink      req,
	twrr_rsp_if.source    rsp,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);
	import twrr_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SPRD   = 3'd3;
	localparam logic [2:0] S_SPDAT  = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0]   state_q;
	req_t         req_q;
	logic [31:0]  interval_q;
	logic [63:0]  tick_q;
	slot_t        cur_q;
	logic [63:0]  cmp_q;
	logic [63:0]  resume_q;
	logic         out_valid_q;
	rsp_t         out_q;

	logic         is_trap;
	logic         is_timer;
	logic         is_soft;
	logic         load_hit;
	scan_ctrl_t   scan_ctrl;
	scan_stat_t   scan_stat;

	logic         sp_we;
	slot_t        sp_waddr;
	logic [63:0]  sp_wdata;
	logic [63:0]  sp_rdata;

	logic         accept;
	logic         out_free;

	// ---- request decode -----------------------------------------------------
	assign is_trap  = (req_q.cmd == CMD_TRAP);
	assign is_timer = is_trap && req_q.irq && (req_q.cause_code == CODE_TIMER);
	assign is_soft  = is_trap && req_q.irq && (req_q.cause_code == CODE_SOFT);
	// drop loads aimed past the end of the table
	assign load_hit = (req_q.cmd == CMD_LOAD) && (32'(req_q.load_index) < TASK_SLOTS);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// ---- table scan unit: wake pass for timer, round-robin pick for soft ----
	always_comb begin
		scan_ctrl.start       = (state_q == S_DECODE) && (is_timer || is_soft);
		scan_ctrl.timer_mode  = is_timer;
		scan_ctrl.first       = is_timer ? '0 : next_slot(cur_q);
		scan_ctrl.load_we     = (state_q == S_DECODE) && load_hit;
		scan_ctrl.load_idx    = slot_t'(req_q.load_index);
		scan_ctrl.load_status = req_q.load_status;
		scan_ctrl.load_wake   = req_q.load_wake;
	end

	twrr_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (scan_ctrl),
		.tick   (tick_q),
		.stat   (scan_stat)
	);

	// ---- saved stack pointers: load writes the entry, soft saves the current one
	always_comb begin
		sp_we    = (state_q == S_DECODE) && (load_hit || is_soft);
		sp_waddr = load_hit ? slot_t'(req_q.load_index) : cur_q;
		sp_wdata = load_hit ? req_q.load_sp : req_q.trap_sp;
	end

	twrr_ram #(.WIDTH(64), .DEPTH(TASK_SLOTS)) u_sp (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (cur_q),
		.rdata (sp_rdata)
	);

	// ---- sequencer ------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			interval_q  <= TICK_INTERVAL_RST;
			tick_q      <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_wdata;
			end
			// post a new result, or drop the one taken at this edge
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (is_timer) begin
						// advance the tick before the wake pass reads it
						tick_q  <= tick_q + 64'd1;
						state_q <= S_SCAN;
					end else if (is_soft) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SCAN: begin
					if (scan_stat.done) begin
						if (is_soft) begin
							// stay on the current task when nothing is ready
							if (scan_stat.found) begin
								cur_q <= scan_stat.hit_idx;
							end
							state_q <= S_SPRD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SPRD: begin
					state_q <= S_SPDAT;
				end
				S_SPDAT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold here while the previous result still waits
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---- payload registers ------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.payload;
		end
		if (state_q == S_DECODE) begin
			cmp_q    <= req_q.mtime_now + {32'd0, interval_q};
			resume_q <= is_trap ? req_q.trap_sp : 64'd0;
		end
		if (state_q == S_SPDAT) begin
			resume_q <= sp_rdata;
		end
		if ((state_q == S_OUT) && out_free) begin
			out_q.resume_sp     <= resume_q;
			out_q.running_index <= 3'(cur_q);
			out_q.compare_value <= is_timer ? cmp_q : 64'd0;
			out_q.compare_write <= is_timer;
			out_q.soft_pending  <= is_timer;
			out_q.soft_write    <= is_timer || is_soft;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// ---- checks -------------------------------------------------------------------
	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DECODE))
		else $error("accepted request did not enter decode");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stat.done |-> (state_q == S_SCAN))
		else $error("scan finished outside the scan state");

	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= slot_t'(TASK_SLOTS - 1))
		else $error("current task index beyond the table");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q && $stable(out_q))
		else $error("waiting result overwritten");

endmodule
